### src/brle_pkg.sv
package brle_pkg;

  localparam int LEN_BITS = 8;
  localparam int CFG_BITS = 8;
  localparam int CFG_INDEX_BITS = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RUN   = 1'd1;

  localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 8'd128;
  localparam logic [CFG_BITS-1:0] MAX_RUN_RESET   = 8'd255;

  // one pixel's worth of output words, as decided by the front end
  typedef struct packed {
    logic [LEN_BITS-1:0] head_len;   // run closed by a color change or split
    logic [LEN_BITS-1:0] flush_len;  // open run flushed at row end
    logic                has_head;
    logic                has_zero;   // zero run of the other color after a split
    logic                has_flush;
  } brle_burst_t;

endpackage

### src/brle_front.sv
module brle_front import brle_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      accept,
  input  logic [7:0]                pixel,
  input  logic                      row_end,
  output logic                      burst_valid,
  output brle_burst_t               burst
);

  localparam int USED_BITS = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
  localparam logic [7:0] PIX_MASK = 8'((1 << USED_BITS) - 1);

  logic [CFG_BITS-1:0] threshold;
  logic [CFG_BITS-1:0] max_run;
  logic                run_color;
  logic [LEN_BITS-1:0] run_count;

  logic                run_color_next;
  logic [LEN_BITS-1:0] run_count_next;
  logic [LEN_BITS-1:0] limit;
  logic                bit_val;
  logic                changed;
  logic                split;
  logic [LEN_BITS-1:0] count_inc;

  always_comb begin
    limit     = (max_run == '0) ? LEN_BITS'(1) : max_run;
    bit_val   = ((pixel & PIX_MASK) > threshold);
    changed   = (bit_val != run_color);
    split     = !changed && (run_count >= limit);
    count_inc = run_count + LEN_BITS'(1);

    burst.head_len  = run_count;
    burst.has_head  = changed || split;
    burst.has_zero  = split;
    burst.has_flush = row_end;
    burst.flush_len = (changed || split) ? LEN_BITS'(1) : count_inc;
    burst_valid     = accept && (changed || split || row_end);

    if (row_end) begin
      run_color_next = 1'b1;
      run_count_next = '0;
    end else if (changed || split) begin
      run_color_next = bit_val;
      run_count_next = LEN_BITS'(1);
    end else begin
      run_color_next = run_color;
      run_count_next = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      max_run   <= MAX_RUN_RESET;
      run_color <= 1'b1;
      run_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: threshold <= cfg_data;
          REG_MAX_RUN:   max_run   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        run_color <= run_color_next;
        run_count <= run_count_next;
      end
    end
  end

endmodule

### src/brle_queue.sv
module brle_queue import brle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  brle_burst_t wr_data,
  output logic        full,
  input  logic        rd_en,
  output logic        rd_valid,
  output brle_burst_t rd_data
);

  brle_burst_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/brle_back.sv
module brle_back import brle_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                burst_valid,
  input  brle_burst_t         burst,
  output logic                burst_pop,
  output logic                empty,
  input  logic                pop,
  output logic [LEN_BITS-1:0] run_length,
  output logic                row_done,
  output logic                burst_last
);

  // words of the current burst already sent: head, zero, flush
  logic [2:0]          sent;
  logic [2:0]          pending;
  logic [2:0]          pick;
  logic [2:0]          rest;
  logic                load;
  logic                out_valid;
  logic [LEN_BITS-1:0] len_sel;

  always_comb begin
    pending = {burst.has_flush, burst.has_zero, burst.has_head} & ~sent;
    pick    = pending & (~pending + 3'd1);   // lowest pending word
    rest    = pending & ~pick;
    load    = burst_valid && (!out_valid || pop);
    burst_pop = load && (rest == 3'b000);
    case (pick)
      3'b001:  len_sel = burst.head_len;
      3'b010:  len_sel = '0;
      default: len_sel = burst.flush_len;
    endcase
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      run_length <= len_sel;
      row_done   <= pick[2];
      burst_last <= (rest == 3'b000);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent      <= 3'b000;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        sent <= (rest == 3'b000) ? 3'b000 : (sent | pick);
      end
    end
  end

endmodule

### src/bilevel_run_length_encoder.sv
// Bilevel run-length encoder. Each pushed word is one gray pixel plus a
// row_end flag; the pixel is compared against threshold (strictly greater
// gives color 1) and runs of equal color come out as alternating lengths,
// each row starting with color 1, so a row opening on color 0 first gives
// a zero-length run. A run that has reached max_run (0 acts as 1) is
// closed when another pixel of its color arrives, followed by a zero run
// of the other color. At row_end the open run is flushed with row_done set.
// A pixel yields zero to three result words; burst_last marks the last one
// that a pixel produced. Pixels with no result produce nothing.
// Rate: a pixel is taken every cycle as long as results are popped; a
// pixel with k results holds the output side until its k words are popped,
// and the two-entry burst queue between the classifier and the output
// sequencer absorbs that, so push only stalls when bursts arrive faster
// than one word per cycle drains. The first result word of a pixel passes
// through the burst queue and then the output register to the result ports.
// Configuration writes (threshold, max_run) take effect at the next edge
// and should be made with the block idle.
module bilevel_run_length_encoder import brle_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  // pixel side
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                pixel,
  input  logic                      row_end,
  // result side
  output logic                      empty,
  input  logic                      pop,
  output logic [LEN_BITS-1:0]       run_length,
  output logic                      row_done,
  output logic                      burst_last
);

  logic        accept;
  logic        fe_valid;
  brle_burst_t fe_burst;
  logic        q_valid;
  brle_burst_t q_burst;
  logic        q_pop;

  // a pushed pixel is taken whenever the burst queue has room
  assign accept = push && !full;

  // front end: thresholding, run tracking, burst classification
  brle_front #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .pixel      (pixel),
    .row_end    (row_end),
    .burst_valid(fe_valid),
    .burst      (fe_burst)
  );

  // decouples pixel intake from word-by-word output
  brle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fe_valid),
    .wr_data (fe_burst),
    .full    (full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_burst)
  );

  // back end: expands each burst into words in the output register
  brle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .burst_valid(q_valid),
    .burst      (q_burst),
    .burst_pop  (q_pop),
    .empty      (empty),
    .pop        (pop),
    .run_length (run_length),
    .row_done   (row_done),
    .burst_last (burst_last)
  );

endmodule
